@@ design/pwm_motif_scan_defines.svh @@
// ----------------------------------------------------------------------------
// pwm_motif_scan_defines.svh
// Assertion macros used by the checker file of the motif scanner.
// ----------------------------------------------------------------------------
`ifndef PWM_MOTIF_SCAN_DEFINES_SVH
`define PWM_MOTIF_SCAN_DEFINES_SVH

// Same-cycle implication on the local clk, masked while arst_n is low
`define PMS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwm_motif_scan: check failed");

// Next-cycle implication on the local clk, masked while arst_n is low
`define PMS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwm_motif_scan: check failed");

`endif

@@ design/pms_pkg.sv @@
// ----------------------------------------------------------------------------
// pms_pkg
// Widths, codes and the cell control word of the motif scanner.
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int MAX_MOTIF = 32;
	localparam int ALPHABET  = 4;

	localparam int WEIGHT_W = 16;
	localparam int SCORE_W  = 21;
	localparam int POS_W    = 24;
	localparam int ROW_W    = 5;
	localparam int BASE_W   = 2;
	localparam int LEN_W    = 6;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// feed word actions
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SYMBOL = 1'b1;

	// register selects (paddr[2])
	localparam logic REG_MOTIF_LEN = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	localparam logic [LEN_W-1:0]          MOTIF_LEN_RST = 6'd32;
	localparam logic signed [SCORE_W-1:0] THRESHOLD_RST = '0;
	localparam logic [POS_W-1:0]          POS_MAX       = {POS_W{1'b1}};
	localparam logic signed [SCORE_W-1:0] SCORE_MIN     = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam logic signed [SCORE_W-1:0] SCORE_MAX     = {1'b0, {(SCORE_W-1){1'b1}}};

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                       shift;
		logic                       load;
		logic [ROW_W-1:0]           row;
		logic [BASE_W-1:0]          col;
		logic [BASE_W-1:0]          base;
		logic signed [WEIGHT_W-1:0] value;
		logic signed [WEIGHT_W:0]   delta;
	} cell_ctrl_t;

endpackage

@@ design/pms_feed_if.sv @@
// ----------------------------------------------------------------------------
// pms_feed_if
// Input channel: weight loads and sequence symbols.
// ----------------------------------------------------------------------------
interface pms_feed_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        action;
	logic [pms_pkg::ROW_W-1:0]                   weight_row;
	logic [pms_pkg::BASE_W-1:0]                  weight_base;
	logic signed [pms_pkg::WEIGHT_W-1:0]         weight_value;
	logic [pms_pkg::BASE_W-1:0]                  base;
	logic                                        seq_start;

	modport source (
		output valid, action, weight_row, weight_base, weight_value, base, seq_start,
		input  ready
	);
	modport sink (
		input  valid, action, weight_row, weight_base, weight_value, base, seq_start,
		output ready
	);
endinterface

@@ design/pms_hit_if.sv @@
// ----------------------------------------------------------------------------
// pms_hit_if
// Output channel: one word per window scoring above threshold.
// ----------------------------------------------------------------------------
interface pms_hit_if;
	logic                                valid;
	logic                                ready;
	logic [pms_pkg::POS_W-1:0]           hit_position;
	logic signed [pms_pkg::SCORE_W-1:0]  hit_score;

	modport source (
		output valid, hit_position, hit_score,
		input  ready
	);
	modport sink (
		input  valid, hit_position, hit_score,
		output ready
	);
endinterface

@@ design/pms_cell.sv @@
// ----------------------------------------------------------------------------
// pms_cell
// One motif position: holds its matrix row, one base of the history and the
// partial score of the window that currently reaches this position.
// ----------------------------------------------------------------------------
module pms_cell #(
	parameter int MAX_MOTIF = pms_pkg::MAX_MOTIF,
	parameter int CELL_IDX  = 0,
	parameter int PSUM_W    = 22
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pms_pkg::cell_ctrl_t                ctrl,
	input  logic [pms_pkg::BASE_W-1:0]         base_in,
	input  logic signed [PSUM_W-1:0]           psum_in,
	input  logic [pms_pkg::BASE_W-1:0]         bases_all [MAX_MOTIF],
	output logic [pms_pkg::BASE_W-1:0]         base_q,
	output logic signed [PSUM_W-1:0]           psum_q,
	output logic signed [pms_pkg::WEIGHT_W-1:0] rd_w
);

	localparam int IDX_W = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

	logic signed [pms_pkg::WEIGHT_W-1:0] weights_q [pms_pkg::ALPHABET];
	logic [pms_pkg::BASE_W-1:0]          rd_addr;
	logic                                row_hit;
	logic                                in_reach;
	logic [IDX_W-1:0]                    offs;
	logic                                fix;

	// read the weight of the incoming base, or of the column being reloaded
	assign rd_addr = ctrl.load ? ctrl.col : ctrl.base;
	assign rd_w    = weights_q[rd_addr];

	assign row_hit  = (32'(ctrl.row) == CELL_IDX);
	assign in_reach = (32'(ctrl.row) <= CELL_IDX);
	assign offs     = IDX_W'(CELL_IDX - int'(ctrl.row));
	// this window used the reloaded entry if its base at that row matches
	assign fix      = ctrl.load && in_reach && (bases_all[offs] == ctrl.col);

	// write own row; entries read as zero until loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '{default: '0};
		end else if (ctrl.load && row_hit) begin
			weights_q[ctrl.col] <= ctrl.value;
		end
	end

	// shift the base history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (ctrl.shift) begin
			base_q <= base_in;
		end
	end

	// advance the partial score, or patch it after a weight reload
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			psum_q <= psum_in + PSUM_W'(rd_w);
		end else if (fix) begin
			psum_q <= psum_q + PSUM_W'(ctrl.delta);
		end
	end

endmodule

@@ design/pwm_motif_scan.sv @@
// ----------------------------------------------------------------------------
// pwm_motif_scan
// Position weight matrix scan over a stream of 2-bit nucleotide codes. The
// matrix is spread over a row of MAX_MOTIF cells; cell j holds row j and the
// partial score of the window whose j-th symbol just arrived, and passes it
// to cell j+1 with each symbol, so a full window score leaves cell
// motif_len-1 every cycle in which a symbol is accepted. A weight reload
// patches the partial scores that used the old weight in the same cycle;
// matrix entries read as zero until loaded. The block takes one feed word
// (weight load or symbol) per cycle while feed.ready is high; a hit word
// passes the score select stage and the output register before it becomes
// valid, and feed.ready drops only while a hit is waiting in the output
// register and the next window also scores above threshold.
// Both configuration registers sit on a 3-bit APB address (0 and 4).
// ----------------------------------------------------------------------------
module pwm_motif_scan #(
	parameter int MAX_MOTIF = pms_pkg::MAX_MOTIF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pms_pkg::APB_AW-1:0]    paddr,
	input  logic [pms_pkg::APB_DW-1:0]    pwdata,
	output logic [pms_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	pms_feed_if.sink                      feed,
	pms_hit_if.source                     hit
);

	localparam int IDX_W  = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;
	localparam int CNT_W  = $clog2(MAX_MOTIF + 1);
	localparam int SUM_W  = pms_pkg::WEIGHT_W + IDX_W + 1;
	localparam int PSUM_W = (SUM_W > pms_pkg::SCORE_W + 1) ? SUM_W : pms_pkg::SCORE_W + 1;
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_MOTIF);

	// configuration
	logic [pms_pkg::LEN_W-1:0]           motif_len_q;
	logic signed [pms_pkg::SCORE_W-1:0]  threshold_q;

	// stream state
	logic [CNT_W-1:0]                    fill_q;
	logic [pms_pkg::POS_W-1:0]           wstart_q;

	// score select stage
	logic                                valid_s1;
	logic [pms_pkg::POS_W-1:0]           pos_s1;
	logic [IDX_W-1:0]                    sel_s1;

	// output register
	logic                                out_valid_q;
	logic [pms_pkg::POS_W-1:0]           out_pos_q;
	logic signed [pms_pkg::SCORE_W-1:0]  out_score_q;

	// cell row
	pms_pkg::cell_ctrl_t                 ctrl;
	logic [pms_pkg::BASE_W-1:0]          bases [MAX_MOTIF];
	logic signed [PSUM_W-1:0]            psum [MAX_MOTIF];
	logic signed [pms_pkg::WEIGHT_W-1:0] rd_w [MAX_MOTIF];

	logic                                feed_acc;
	logic                                is_sym;
	logic                                load_ok;
	logic [CNT_W-1:0]                    m_eff;
	logic [CNT_W-1:0]                    fill_base;
	logic [CNT_W-1:0]                    fill_nx;
	logic [pms_pkg::POS_W-1:0]           pos_base;
	logic                                score_now;
	logic signed [PSUM_W-1:0]            win_sum;
	logic signed [pms_pkg::SCORE_W-1:0]  win_score;
	logic                                is_hit;
	logic                                s1_adv;

	// APB register file
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motif_len_q <= pms_pkg::MOTIF_LEN_RST;
			threshold_q <= pms_pkg::THRESHOLD_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				pms_pkg::REG_MOTIF_LEN: motif_len_q <= pwdata[pms_pkg::LEN_W-1:0];
				pms_pkg::REG_THRESHOLD: threshold_q <= pwdata[pms_pkg::SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			pms_pkg::REG_MOTIF_LEN: prdata = pms_pkg::APB_DW'(motif_len_q);
			pms_pkg::REG_THRESHOLD: prdata = pms_pkg::APB_DW'(threshold_q);
			default:                prdata = '0;
		endcase
	end

	// clamp the window length to 1..MAX_MOTIF
	always_comb begin
		if (motif_len_q == '0) begin
			m_eff = CNT_W'(1);
		end else if (int'(motif_len_q) > MAX_MOTIF) begin
			m_eff = FILL_MAX;
		end else begin
			m_eff = CNT_W'(motif_len_q);
		end
	end

	// feed decode
	assign feed_acc = feed.valid && feed.ready;
	assign is_sym   = (feed.action == pms_pkg::ACT_SYMBOL);
	assign load_ok  = (int'(feed.weight_row) < MAX_MOTIF);

	assign fill_base = feed.seq_start ? '0 : fill_q;
	assign fill_nx   = (fill_base < FILL_MAX) ? fill_base + 1'b1 : fill_base;
	assign pos_base  = feed.seq_start ? '0 : wstart_q;
	assign score_now = (fill_nx >= m_eff);

	// broadcast to the cells
	always_comb begin
		ctrl.shift = feed_acc && is_sym;
		ctrl.load  = feed_acc && !is_sym && load_ok;
		ctrl.row   = feed.weight_row;
		ctrl.col   = feed.weight_base;
		ctrl.base  = feed.base;
		ctrl.value = feed.weight_value;
		ctrl.delta = (pms_pkg::WEIGHT_W+1)'(feed.weight_value)
			- (pms_pkg::WEIGHT_W+1)'(rd_w[IDX_W'(feed.weight_row)]);
	end

	for (genvar j = 0; j < MAX_MOTIF; j++) begin : g_cell
		logic [pms_pkg::BASE_W-1:0] base_in;
		logic signed [PSUM_W-1:0]   psum_in;

		if (j == 0) begin : g_head
			assign base_in = feed.base;
			assign psum_in = '0;
		end else begin : g_body
			assign base_in = bases[j-1];
			assign psum_in = psum[j-1];
		end

		pms_cell #(
			.MAX_MOTIF (MAX_MOTIF),
			.CELL_IDX  (j),
			.PSUM_W    (PSUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.base_in   (base_in),
			.psum_in   (psum_in),
			.bases_all (bases),
			.base_q    (bases[j]),
			.psum_q    (psum[j]),
			.rd_w      (rd_w[j])
		);
	end

	// track fill and window start per sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wstart_q <= '0;
		end else if (ctrl.shift) begin
			fill_q <= fill_nx;
			if (score_now && (pos_base != pms_pkg::POS_MAX)) begin
				wstart_q <= pos_base + 1'b1;
			end else begin
				wstart_q <= pos_base;
			end
		end
	end

	// pick the finished window and saturate it
	assign win_sum = psum[sel_s1];

	always_comb begin
		if (win_sum < PSUM_W'(pms_pkg::SCORE_MIN)) begin
			win_score = pms_pkg::SCORE_MIN;
		end else if (win_sum > PSUM_W'(pms_pkg::SCORE_MAX)) begin
			win_score = pms_pkg::SCORE_MAX;
		end else begin
			win_score = pms_pkg::SCORE_W'(win_sum);
		end
	end

	assign is_hit     = valid_s1 && (win_score > threshold_q);
	assign s1_adv     = !is_hit || !out_valid_q || hit.ready;
	assign feed.ready = s1_adv;

	// score select stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.shift) begin
			valid_s1 <= score_now;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			pos_s1 <= pos_base;
			sel_s1 <= IDX_W'(m_eff - 1'b1);
		end
	end

	// output register: load a hit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_hit && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (hit.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit && s1_adv) begin
			out_pos_q   <= pos_s1;
			out_score_q <= win_score;
		end
	end

	assign hit.valid        = out_valid_q;
	assign hit.hit_position = out_pos_q;
	assign hit.hit_score    = out_score_q;

endmodule

@@ design/pms_checker.sv @@
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks of the motif scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "pwm_motif_scan_defines.svh"

module pms_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               feed_valid,
	input logic                               feed_ready,
	input logic                               feed_action,
	input logic                               hit_valid,
	input logic                               hit_ready,
	input logic [pms_pkg::POS_W-1:0]          hit_position,
	input logic signed [pms_pkg::SCORE_W-1:0] hit_score
);

	// a new hit word comes from an accepted symbol
	`PMS_ASSERT_IMP(a_hit_from_symbol, $rose(hit_valid), $past(feed_valid && feed_ready && (feed_action == pms_pkg::ACT_SYMBOL), 2))

	// the feed stalls only behind a hit word that is not taken
	`PMS_ASSERT_IMP(a_stall_cause, !feed_ready, hit_valid && !hit_ready)

	// hold a waiting hit word
	`PMS_ASSERT_NXT(a_hit_hold, hit_valid && !hit_ready, hit_valid && $stable(hit_position) && $stable(hit_score))

endmodule

bind pwm_motif_scan pms_checker u_pms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.feed_valid   (feed.valid),
	.feed_ready   (feed.ready),
	.feed_action  (feed.action),
	.hit_valid    (hit.valid),
	.hit_ready    (hit.ready),
	.hit_position (hit.hit_position),
	.hit_score    (hit.hit_score)
);
